// ===== rtl/core/gvtd_pkg.sv =====
// Shared constants, types and the arctangent table of the up-vector tumble detector.
package gvtd_pkg;

  // Iteration limits
  localparam int unsigned CORDIC_ITERS_DEF = 16;
  localparam int unsigned TABLE_LEN        = 24;
  localparam int unsigned IDX_W            = $clog2(TABLE_LEN + 1);

  // Datapath widths
  localparam int unsigned CW   = 34;   // CORDIC x, y, z
  localparam int unsigned SQ_W = 58;   // square-root radicand (even)
  localparam int unsigned DV_N = 38;   // divider dividend and quotient
  localparam int unsigned DV_D = 25;   // divider divisor

  // Fixed-point constants
  localparam logic signed [CW-1:0] GAIN_Q30     = 34'sd652032874;
  localparam logic signed [CW-1:0] ANGLE_SCALE  = 34'sd2867080551;
  localparam logic signed [CW-1:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [CW-1:0] HALF_TURN    = 34'sd2147483648;

  // One CORDIC job: mode and start values
  typedef struct packed {
    logic                 vec_mode;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_req_t;

  // atan(2^-i) in binary-angle units (2^32 per turn)
  function automatic logic signed [CW-1:0] atan_turns(input logic [IDX_W-1:0] i);
    logic signed [CW-1:0] v;
    case (i)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10679838;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/gvtd_ifs.sv =====
// Valid/ready channel interfaces for requests and results.
interface gvtd_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [15:0] rate_x;
  logic signed [15:0] rate_y;
  logic signed [15:0] rate_z;
  logic        [15:0] elapsed_us;
  logic signed [15:0] grav_x;
  logic signed [15:0] grav_y;
  logic signed [15:0] grav_z;

  modport source (output valid, func, rate_x, rate_y, rate_z, elapsed_us,
                  grav_x, grav_y, grav_z, input ready);
  modport sink (input valid, func, rate_x, rate_y, rate_z, elapsed_us,
                grav_x, grav_y, grav_z, output ready);
endinterface

interface gvtd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] up_x;
  logic signed [15:0] up_y;
  logic signed [15:0] up_z;
  logic        [15:0] turned;
  logic               tumbled;
  logic               gravity_low;

  modport source (output valid, up_x, up_y, up_z, turned, tumbled, gravity_low,
                  input ready);
  modport sink (input valid, up_x, up_y, up_z, turned, tumbled, gravity_low,
                output ready);
endinterface

// ===== rtl/core/gvtd_cordic.sv =====
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
module gvtd_cordic #(
  parameter int unsigned ITERS = gvtd_pkg::CORDIC_ITERS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  gvtd_pkg::cordic_req_t             req,
  output logic                              done,
  output logic signed [gvtd_pkg::CW-1:0]    x_o,
  output logic signed [gvtd_pkg::CW-1:0]    y_o,
  output logic signed [gvtd_pkg::CW-1:0]    z_o
);
  import gvtd_pkg::*;

  localparam int unsigned N = (ITERS > TABLE_LEN) ? TABLE_LEN : ITERS;

  logic                 busy_r, done_r, mode_r;
  logic [IDX_W-1:0]     idx_r;
  logic signed [CW-1:0] x_r, y_r, z_r;
  logic signed [CW-1:0] dx, dy, ang;
  logic                 pos;

  // Direction: drive z to zero (rotation) or y to zero (vectoring)
  always_comb begin
    dx  = y_r >>> idx_r;
    dy  = x_r >>> idx_r;
    ang = atan_turns(idx_r);
    pos = mode_r ? !(y_r > 0) : (z_r >= 0);
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (busy_r) begin
        idx_r <= idx_r + 1'b1;
        if (idx_r == IDX_W'(N - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      mode_r <= req.vec_mode;
      x_r    <= req.x;
      y_r    <= req.y;
      z_r    <= req.z;
    end else if (busy_r) begin
      if (pos) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - ang;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + ang;
      end
    end
  end

  assign done = done_r;
  assign x_o  = x_r;
  assign y_o  = y_r;
  assign z_o  = z_r;

endmodule

// ===== rtl/core/gvtd_sqrt.sv =====
// Bit-serial integer square root, one result bit per cycle.
module gvtd_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [gvtd_pkg::SQ_W-1:0]  value,
  output logic                       done,
  output logic [gvtd_pkg::SQ_W-1:0]  root
);
  import gvtd_pkg::*;

  logic              busy_r, done_r;
  logic [SQ_W-1:0]   v_r, r_r, bit_r;
  logic [SQ_W-1:0]   trial;

  assign trial = r_r + bit_r;

  // Control: finishes after the lowest bit position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Restoring root step
  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= value;
      r_r   <= '0;
      bit_r <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_r <= v_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r;

endmodule

// ===== rtl/core/gvtd_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module gvtd_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [gvtd_pkg::DV_N-1:0]  dividend,
  input  logic [gvtd_pkg::DV_D-1:0]  divisor,
  output logic                       done,
  output logic [gvtd_pkg::DV_N-1:0]  quot
);
  import gvtd_pkg::*;

  localparam int unsigned CNT_W = $clog2(DV_N);

  logic              busy_r, done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DV_N-1:0]   q_r;
  logic [DV_D-1:0]   d_r, rem_r;
  logic [DV_D:0]     rem2;
  logic              fits;

  always_comb begin
    rem2 = {rem_r, q_r[DV_N-1]};
    fits = rem2 >= {1'b0, d_r};
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DV_N - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift dividend out, quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      d_r   <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? DV_D'(rem2 - {1'b0, d_r}) : rem2[DV_D-1:0];
      q_r   <= {q_r[DV_N-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== rtl/core/gyro_up_vector_tumble_detector_unit.sv =====
// Top level: sequencer, shared multiplier and state of the up-vector tumble detector.
//
// One request at a time; in_ch.ready is high only while the sequencer is idle. A gyro
// step rotates the up vector about each axis in turn: the step angle, the shared CORDIC
// and the rotation. The tilt angle then takes the dot product, the square root and the
// vectoring CORDIC, and one more state loads the result. A re-zero takes the squares and
// the gravity check, the root, three divides and the same tilt angle. A weak-gravity
// re-zero skips the root and the divides. A finished result waits in the output register
// while the next request is already taken. The sequencer waits in its last state only
// while the previous result is still unread.
module gyro_up_vector_tumble_detector_unit #(
  parameter int unsigned CORDIC_ITERS = gvtd_pkg::CORDIC_ITERS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  gvtd_in_if.sink     in_ch,
  gvtd_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [15:0] cfg_wdata
);
  import gvtd_pkg::*;

  localparam logic CFG_MIN_ROTATION = 1'b0;
  localparam logic CFG_MIN_GRAVITY  = 1'b1;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RATE  = 5'd1;
  localparam logic [4:0] S_SCALE = 5'd2;
  localparam logic [4:0] S_THETA = 5'd3;
  localparam logic [4:0] S_SC    = 5'd4;
  localparam logic [4:0] S_R0    = 5'd5;
  localparam logic [4:0] S_R1    = 5'd6;
  localparam logic [4:0] S_R2    = 5'd7;
  localparam logic [4:0] S_R3    = 5'd8;
  localparam logic [4:0] S_R4    = 5'd9;
  localparam logic [4:0] S_G0    = 5'd10;
  localparam logic [4:0] S_G1    = 5'd11;
  localparam logic [4:0] S_G2    = 5'd12;
  localparam logic [4:0] S_G3    = 5'd13;
  localparam logic [4:0] S_G4    = 5'd14;
  localparam logic [4:0] S_GSQ   = 5'd15;
  localparam logic [4:0] S_GDIV  = 5'd16;
  localparam logic [4:0] S_GDW   = 5'd17;
  localparam logic [4:0] S_D0    = 5'd18;
  localparam logic [4:0] S_D1    = 5'd19;
  localparam logic [4:0] S_D2    = 5'd20;
  localparam logic [4:0] S_D3    = 5'd21;
  localparam logic [4:0] S_D4    = 5'd22;
  localparam logic [4:0] S_D5    = 5'd23;
  localparam logic [4:0] S_D6    = 5'd24;
  localparam logic [4:0] S_D7    = 5'd25;
  localparam logic [4:0] S_D8    = 5'd26;
  localparam logic [4:0] S_OUT   = 5'd27;

  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  // Saturate a wide value to the Q1.14 unit range
  function automatic logic signed [15:0] sat14(input logic signed [47:0] v);
    logic signed [15:0] r;
    if (v > 48'sd16384)       r = ONE_Q14;
    else if (v < -48'sd16384) r = -ONE_Q14;
    else                      r = v[15:0];
    return r;
  endfunction

  // Configuration
  logic [15:0] min_rotation_r;
  logic [11:0] min_gravity_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_rotation_r <= 16'd8192;
      min_gravity_r  <= 12'd800;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MIN_ROTATION: min_rotation_r <= cfg_wdata;
        CFG_MIN_GRAVITY:  min_gravity_r  <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers
  logic [4:0]           state_r, state_nxt;
  logic [1:0]           k_r;
  logic                 func_r;
  logic signed [15:0]   rate_r [3];
  logic signed [15:0]   grav_r [3];
  logic [15:0]          us_r;
  logic signed [15:0]   up_r [3];
  logic signed [15:0]   st_r [3];
  logic signed [67:0]   prod_r;
  logic signed [33:0]   mul_a, mul_b;
  logic                 pneg_r, flip_r, low_r;
  logic signed [CW-1:0] c_r, s_r;
  logic signed [47:0]   acc_a_r, acc_b_r;
  logic [31:0]          sum_r;
  logic signed [31:0]   dacc_r;
  logic signed [29:0]   d_r;
  logic [DV_D-1:0]      m_r;

  logic [31:0]          absp;
  logic [63:0]          qround;
  logic [31:0]          theta;
  logic signed [CW-1:0] zs, zf;
  logic                 fold;
  logic [1:0]           ia, ib;
  logic signed [15:0]   na, nb;
  logic [15:0]          absg;
  logic [28:0]          absd;
  logic signed [CW-1:0] zt;
  logic signed [17:0]   zsh;
  logic [15:0]          turned;

  // Shared unit handshakes
  logic                 cor_start, cor_done;
  cordic_req_t          cor_req;
  logic signed [CW-1:0] cor_x, cor_y, cor_z;
  logic                 sq_start, sq_done;
  logic [SQ_W-1:0]      sq_val, sq_root;
  logic                 dv_start, dv_done;
  logic [DV_N-1:0]      dv_num, dv_quot;

  // Rotation pair per axis: (y,z), (z,x), (x,y)
  always_comb begin
    case (k_r)
      2'd0:    begin ia = 2'd1; ib = 2'd2; end
      2'd1:    begin ia = 2'd2; ib = 2'd0; end
      default: begin ia = 2'd0; ib = 2'd1; end
    endcase
  end

  // Step angle, fold into +-quarter turn, rotation rounding
  always_comb begin
    absp   = prod_r[31] ? 32'(-prod_r[31:0]) : prod_r[31:0];
    qround = prod_r[63:0] + 64'h8000_0000;
    theta  = pneg_r ? 32'(-qround[63:32]) : qround[63:32];
    zs     = CW'($signed(theta));
    fold   = 1'b0;
    zf     = zs;
    if (zs > QUARTER_TURN) begin
      zf   = zs - HALF_TURN;
      fold = 1'b1;
    end else if (zs < -QUARTER_TURN) begin
      zf   = zs + HALF_TURN;
      fold = 1'b1;
    end
    na   = sat14((acc_a_r + 48'sd536870912) >>> 30);
    nb   = sat14((acc_b_r + $signed(prod_r[47:0]) + 48'sd536870912) >>> 30);
    absg = grav_r[k_r][15] ? 16'(-grav_r[k_r]) : grav_r[k_r];
    absd = d_r[29] ? 29'(-d_r) : d_r[28:0];
    zt   = cor_z + CW'(32768);
    zsh  = 18'(zt >>> 16);
    if (zsh < 18'sd0)          turned = 16'd0;
    else if (zsh > 18'sd32768) turned = 16'd32768;
    else                       turned = zsh[15:0];
  end

  // Shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_RATE:  begin mul_a = 34'(rate_r[k_r]); mul_b = 34'($signed({1'b0, us_r})); end
      S_SCALE: begin mul_a = $signed({2'b00, absp}); mul_b = ANGLE_SCALE; end
      S_R0:    begin mul_a = 34'(up_r[ia]); mul_b = c_r; end
      S_R1:    begin mul_a = 34'(up_r[ib]); mul_b = s_r; end
      S_R2:    begin mul_a = 34'(up_r[ia]); mul_b = s_r; end
      S_R3:    begin mul_a = 34'(up_r[ib]); mul_b = c_r; end
      S_G0:    begin mul_a = 34'(grav_r[0]); mul_b = 34'(grav_r[0]); end
      S_G1:    begin mul_a = 34'(grav_r[1]); mul_b = 34'(grav_r[1]); end
      S_G2:    begin mul_a = 34'(grav_r[2]); mul_b = 34'(grav_r[2]); end
      S_G3:    begin
        mul_a = $signed({22'd0, min_gravity_r});
        mul_b = $signed({22'd0, min_gravity_r});
      end
      S_D0:    begin mul_a = 34'(up_r[0]); mul_b = 34'(st_r[0]); end
      S_D1:    begin mul_a = 34'(up_r[1]); mul_b = 34'(st_r[1]); end
      S_D2:    begin mul_a = 34'(up_r[2]); mul_b = 34'(st_r[2]); end
      S_D5:    begin mul_a = $signed({5'd0, absd}); mul_b = $signed({5'd0, absd}); end
      default: ;
    endcase
  end

  // Unit starts and job setup
  always_comb begin
    cor_start = (state_r == S_THETA) || (state_r == S_D7 && sq_done);
    cor_req.vec_mode = (state_r == S_D7);
    cor_req.x = GAIN_Q30;
    cor_req.y = '0;
    cor_req.z = zf;
    if (state_r == S_D7) begin
      if (d_r[29]) begin
        cor_req.x = CW'(sq_root);
        cor_req.y = CW'(-d_r);
        cor_req.z = QUARTER_TURN;
      end else begin
        cor_req.x = CW'(d_r);
        cor_req.y = CW'(sq_root);
        cor_req.z = '0;
      end
    end
    sq_start = ((state_r == S_G4) && (sum_r != 32'd0) && (64'(sum_r) >= prod_r[63:0]))
               || (state_r == S_D6);
    sq_val   = (state_r == S_G4) ? SQ_W'({sum_r, 16'd0})
                                 : SQ_W'((SQ_W'(1) << 56) - prod_r[SQ_W-1:0]);
    dv_start = (state_r == S_GDIV);
    dv_num   = DV_N'({absg, 22'd0}) + DV_N'(m_r >> 1);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_ch.valid) state_nxt = in_ch.func ? S_G0 : S_RATE;
      S_RATE:  state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_THETA;
      S_THETA: state_nxt = S_SC;
      S_SC:    if (cor_done) state_nxt = S_R0;
      S_R0:    state_nxt = S_R1;
      S_R1:    state_nxt = S_R2;
      S_R2:    state_nxt = S_R3;
      S_R3:    state_nxt = S_R4;
      S_R4:    state_nxt = (k_r == 2'd2) ? S_D0 : S_RATE;
      S_G0:    state_nxt = S_G1;
      S_G1:    state_nxt = S_G2;
      S_G2:    state_nxt = S_G3;
      S_G3:    state_nxt = S_G4;
      S_G4:    state_nxt = sq_start ? S_GSQ : S_D0;
      S_GSQ:   if (sq_done) state_nxt = S_GDIV;
      S_GDIV:  state_nxt = S_GDW;
      S_GDW:   if (dv_done) state_nxt = (k_r == 2'd2) ? S_D0 : S_GDIV;
      S_D0:    state_nxt = S_D1;
      S_D1:    state_nxt = S_D2;
      S_D2:    state_nxt = S_D3;
      S_D3:    state_nxt = S_D4;
      S_D4:    state_nxt = S_D5;
      S_D5:    state_nxt = S_D6;
      S_D6:    state_nxt = S_D7;
      S_D7:    if (sq_done) state_nxt = S_D8;
      S_D8:    if (cor_done) state_nxt = S_OUT;
      S_OUT:   if (!out_ch.valid || out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers and stored vectors
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      up_r    <= '{16'sd0, 16'sd0, ONE_Q14};
      st_r    <= '{16'sd0, 16'sd0, ONE_Q14};
      out_ch.valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // result valid: load a new result or drop once it is taken
      if (state_r == S_OUT && (!out_ch.valid || out_ch.ready)) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      case (state_r)
        S_IDLE: k_r <= '0;
        S_R4: begin
          up_r[ia] <= na;
          up_r[ib] <= nb;
          k_r      <= k_r + 1'b1;
        end
        S_G4: if (!sq_start) begin
          up_r <= '{16'sd0, 16'sd0, ONE_Q14};
          st_r <= '{16'sd0, 16'sd0, ONE_Q14};
        end
        S_GDW: if (dv_done) begin
          if (dv_quot > DV_N'(16384)) begin
            up_r[k_r] <= grav_r[k_r] > 0 ? -ONE_Q14 : ONE_Q14;
            st_r[k_r] <= grav_r[k_r] > 0 ? -ONE_Q14 : ONE_Q14;
          end else begin
            up_r[k_r] <= grav_r[k_r] > 0 ? 16'(-dv_quot[15:0]) : dv_quot[15:0];
            st_r[k_r] <= grav_r[k_r] > 0 ? 16'(-dv_quot[15:0]) : dv_quot[15:0];
          end
          k_r <= k_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      S_IDLE: if (in_ch.valid) begin
        func_r    <= in_ch.func;
        rate_r[0] <= in_ch.rate_x;
        rate_r[1] <= in_ch.rate_y;
        rate_r[2] <= in_ch.rate_z;
        us_r      <= in_ch.elapsed_us;
        grav_r[0] <= in_ch.grav_x;
        grav_r[1] <= in_ch.grav_y;
        grav_r[2] <= in_ch.grav_z;
        low_r     <= 1'b0;
      end
      S_SCALE: pneg_r <= prod_r[31];
      S_THETA: flip_r <= fold;
      S_SC: if (cor_done) begin
        c_r <= flip_r ? -cor_x : cor_x;
        s_r <= flip_r ? -cor_y : cor_y;
      end
      S_R1: acc_a_r <= prod_r[47:0];
      S_R2: acc_a_r <= acc_a_r - prod_r[47:0];
      S_R3: acc_b_r <= prod_r[47:0];
      S_G1: sum_r <= prod_r[31:0];
      S_G2: sum_r <= sum_r + prod_r[31:0];
      S_G3: sum_r <= sum_r + prod_r[31:0];
      S_G4: low_r <= !sq_start;
      S_GSQ: if (sq_done) m_r <= sq_root[DV_D-1:0];
      S_D1: dacc_r <= prod_r[31:0];
      S_D2: dacc_r <= dacc_r + prod_r[31:0];
      S_D3: dacc_r <= dacc_r + prod_r[31:0];
      S_D4: begin
        if (dacc_r > 32'sd268435456)       d_r <= 30'sd268435456;
        else if (dacc_r < -32'sd268435456) d_r <= -30'sd268435456;
        else                               d_r <= dacc_r[29:0];
      end
      S_OUT: if (!out_ch.valid || out_ch.ready) begin
        out_ch.up_x        <= up_r[0];
        out_ch.up_y        <= up_r[1];
        out_ch.up_z        <= up_r[2];
        out_ch.turned      <= turned;
        out_ch.tumbled     <= turned > min_rotation_r;
        out_ch.gravity_low <= low_r && func_r;
      end
      default: ;
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE);

  // Shared units
  gvtd_cordic #(.ITERS(CORDIC_ITERS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .req   (cor_req),
    .done  (cor_done),
    .x_o   (cor_x),
    .y_o   (cor_y),
    .z_o   (cor_z)
  );

  gvtd_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .value (sq_val),
    .done  (sq_done),
    .root  (sq_root)
  );

  gvtd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend (dv_num),
    .divisor  (m_r),
    .done     (dv_done),
    .quot     (dv_quot)
  );

endmodule

// ===== tb/sv/gvtd_tb_pkg.sv =====
`timescale 1ns / 1ps
// Request and result records shared by the up-vector tumble detector testbench.
package gvtd_tb_pkg;

  // Request functions
  typedef enum logic {
    FN_STEP   = 1'b0,
    FN_REZERO = 1'b1
  } func_e;

  // Register indexes
  localparam logic REG_MIN_ROTATION = 1'b0;
  localparam logic REG_MIN_GRAVITY  = 1'b1;

  typedef struct packed {
    func_e              func;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic        [15:0] elapsed_us;
    logic signed [15:0] grav_x;
    logic signed [15:0] grav_y;
    logic signed [15:0] grav_z;
  } tilt_req_t;

  typedef struct packed {
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
    logic        [15:0] turned;
    logic               tumbled;
    logic               gravity_low;
  } tilt_res_t;

endpackage

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the up-vector tumble detector with a built-in predictor.
module testbench;
  import gvtd_pkg::*;
  import gvtd_tb_pkg::*;

  localparam int NUM_RANDOM = 600;
  localparam longint ANG_SCALE = 64'd2867080551;
  localparam longint QTR = 64'sd1073741824;
  localparam longint HLF = 64'sd2147483648;
  localparam longint GAIN = 64'sd652032874;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_idx = 1'b0;
  logic [15:0] cfg_wdata = '0;

  gvtd_in_if  in_ch ();
  gvtd_out_if out_ch ();

  gyro_up_vector_tumble_detector_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // Clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state
  longint up_v[3];
  longint start_v[3];
  longint thr_rot;
  longint thr_grav;

  tilt_req_t pending_reqs[$];
  tilt_res_t expected_res[$];
  int n_fail = 0;
  int n_results = 0;
  int n_low = 0;
  int n_tumbled = 0;

  // Floor shift of a signed value
  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp14(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  // Binary angle (2^32 per turn) of rate times elapsed time
  function automatic logic [31:0] rot_angle(logic signed [15:0] rate, logic [15:0] us);
    longint p;
    longint unsigned mag, q;
    p = longint'(rate) * longint'({1'b0, us});
    mag = (p < 0) ? -p : p;
    q = (mag * ANG_SCALE + 64'd2147483648) >> 32;
    return (p < 0) ? (32'd0 - q[31:0]) : q[31:0];
  endfunction

  // Rotation-mode CORDIC with half-turn fold
  function automatic void sin_cos(input logic [31:0] theta, output longint c,
                                  output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'({32'd0, theta});
    x = GAIN;
    y = 0;
    flip = 0;
    if (z >= HLF) z = z - 2 * HLF;
    if (z > QTR) begin
      z = z - HLF;
      flip = 1;
    end else if (z < -QTR) begin
      z = z + HLF;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_ITERS_DEF; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_turns(IDX_W'(i)));
      end else begin
        x += dx; y -= dy; z += longint'(atan_turns(IDX_W'(i)));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic void spin(int ia, int ib, logic [31:0] theta);
    longint c, s, a, b;
    sin_cos(theta, c, s);
    a = up_v[ia];
    b = up_v[ib];
    up_v[ia] = clamp14(fshr(a * c - b * s + (64'sd1 << 29), 30));
    up_v[ib] = clamp14(fshr(a * s + b * c + (64'sd1 << 29), 30));
  endfunction

  // Angle between up and start vectors, turns*65536
  function automatic longint tilt_turns();
    longint d, x, y, z, dx, dy, t;
    d = 0;
    z = 0;
    for (int i = 0; i < 3; i++) d += up_v[i] * start_v[i];
    if (d > (64'sd1 << 28)) d = 64'sd1 << 28;
    if (d < -(64'sd1 << 28)) d = -(64'sd1 << 28);
    x = d;
    y = int_sqrt((64'd1 << 56) - d * d);
    if (x < 0) begin
      t = x; x = y; y = -t; z = QTR;
    end
    for (int i = 0; i < CORDIC_ITERS_DEF; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(atan_turns(IDX_W'(i)));
      end else begin
        x -= dx; y += dy; z -= longint'(atan_turns(IDX_W'(i)));
      end
    end
    z = fshr(z + 32768, 16);
    if (z < 0) z = 0;
    if (z > 32768) z = 32768;
    return z;
  endfunction

  function automatic void track_reset();
    for (int i = 0; i < 3; i++) begin
      up_v[i] = (i == 2) ? 16384 : 0;
      start_v[i] = up_v[i];
    end
    thr_rot = 8192;
    thr_grav = 800;
  endfunction

  // Advance the tracker by one request and queue its result
  function automatic void track_request(tilt_req_t r);
    tilt_res_t e;
    longint g[3];
    longint unsigned sum, m8, a;
    longint q, t;
    e = '0;
    if (r.func == FN_STEP) begin
      spin(1, 2, rot_angle(r.rate_x, r.elapsed_us));
      spin(2, 0, rot_angle(r.rate_y, r.elapsed_us));
      spin(0, 1, rot_angle(r.rate_z, r.elapsed_us));
    end else begin
      g[0] = r.grav_x; g[1] = r.grav_y; g[2] = r.grav_z;
      sum = 0;
      for (int i = 0; i < 3; i++) sum += g[i] * g[i];
      if (sum == 0 || sum < thr_grav * thr_grav) begin
        e.gravity_low = 1'b1;
        for (int i = 0; i < 3; i++) up_v[i] = (i == 2) ? 16384 : 0;
      end else begin
        m8 = int_sqrt(sum << 16);
        for (int i = 0; i < 3; i++) begin
          a = (g[i] < 0) ? -g[i] : g[i];
          q = ((a << 22) + m8 / 2) / m8;
          up_v[i] = clamp14(g[i] > 0 ? -q : q);
        end
      end
      for (int i = 0; i < 3; i++) start_v[i] = up_v[i];
    end
    t = tilt_turns();
    e.up_x = up_v[0];
    e.up_y = up_v[1];
    e.up_z = up_v[2];
    e.turned = t;
    e.tumbled = (t > thr_rot);
    expected_res.push_back(e);
  endfunction

  // Handshakes seen at the last rising edge
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  always @(posedge clk) begin
    in_taken  <= rst_n && in_ch.valid && in_ch.ready;
    out_taken <= rst_n && out_ch.valid && out_ch.ready;
  end

  // Driver: present pending requests with random gaps
  int gap_in = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_in <= 0;
    end else if (in_ch.valid && !in_taken) begin
      // hold until taken
    end else if (gap_in > 0) begin
      in_ch.valid <= 1'b0;
      gap_in <= gap_in - 1;
    end else if (pending_reqs.size() > 0) begin
      in_ch.valid <= 1'b1;
      {in_ch.func, in_ch.rate_x, in_ch.rate_y, in_ch.rate_z, in_ch.elapsed_us,
       in_ch.grav_x, in_ch.grav_y, in_ch.grav_z} <= pending_reqs.pop_front();
      gap_in <= $urandom_range(0, 4);
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Predict at acceptance
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      track_request({in_ch.func, in_ch.rate_x, in_ch.rate_y, in_ch.rate_z,
                     in_ch.elapsed_us, in_ch.grav_x, in_ch.grav_y, in_ch.grav_z});
  end

  // Result stall pattern: a fresh wait is drawn after every taken result
  int stall_out = 0;
  always @(negedge clk) begin
    int w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_out <= 0;
    end else begin
      w = out_taken ? int'($urandom_range(0, 4)) : stall_out;
      if (w > 0) begin
        out_ch.ready <= 1'b0;
        stall_out <= w - 1;
      end else begin
        out_ch.ready <= 1'b1;
        stall_out <= 0;
      end
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    tilt_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_res.size() == 0) begin
        $error("result with no request outstanding");
        n_fail++;
      end else begin
        e = expected_res.pop_front();
        n_results++;
        if (e.gravity_low) n_low++;
        if (e.tumbled) n_tumbled++;
        if (out_ch.up_x !== e.up_x) begin
          $error("up_x expected %0d actual %0d", e.up_x, out_ch.up_x); n_fail++;
        end
        if (out_ch.up_y !== e.up_y) begin
          $error("up_y expected %0d actual %0d", e.up_y, out_ch.up_y); n_fail++;
        end
        if (out_ch.up_z !== e.up_z) begin
          $error("up_z expected %0d actual %0d", e.up_z, out_ch.up_z); n_fail++;
        end
        if (out_ch.turned !== e.turned) begin
          $error("turned expected %0d actual %0d", e.turned, out_ch.turned); n_fail++;
        end
        if (out_ch.tumbled !== e.tumbled) begin
          $error("tumbled expected %0d actual %0d", e.tumbled, out_ch.tumbled); n_fail++;
        end
        if (out_ch.gravity_low !== e.gravity_low) begin
          $error("gravity_low expected %0d actual %0d", e.gravity_low,
                 out_ch.gravity_low);
          n_fail++;
        end
      end
    end
  end

  function automatic tilt_req_t step_req(int rx, int ry, int rz, int us);
    tilt_req_t r;
    r = '0;
    r.func = FN_STEP;
    r.rate_x = rx; r.rate_y = ry; r.rate_z = rz; r.elapsed_us = us;
    r.grav_x = $urandom; r.grav_y = $urandom; r.grav_z = $urandom;
    return r;
  endfunction

  function automatic tilt_req_t rezero_req(int gx, int gy, int gz);
    tilt_req_t r;
    r = '0;
    r.func = FN_REZERO;
    r.grav_x = gx; r.grav_y = gy; r.grav_z = gz;
    r.rate_x = $urandom; r.rate_y = $urandom; r.rate_z = $urandom;
    r.elapsed_us = $urandom;
    return r;
  endfunction

  function automatic tilt_req_t random_req();
    tilt_req_t r;
    int k;
    k = $urandom_range(0, 9);
    if (k < 6) begin
      // typical gyro step: moderate rates, elapsed time up to 20 ms
      r = step_req($signed(16'($urandom_range(0, 8000) - 4000)),
                   $signed(16'($urandom_range(0, 8000) - 4000)),
                   $signed(16'($urandom_range(0, 8000) - 4000)),
                   $urandom_range(0, 20000));
    end else if (k < 8) begin
      r = step_req($urandom, $urandom, $urandom, $urandom);
    end else if (k < 9) begin
      r = rezero_req($signed(16'($urandom_range(0, 200) - 100)),
                     $signed(16'($urandom_range(0, 200) - 100)),
                     $signed(16'($urandom_range(0, 2000) - 1000)));
    end else begin
      r = rezero_req($urandom, $urandom, $urandom);
    end
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_res.size() != 0 || in_ch.valid)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MIN_ROTATION) thr_rot = val;
    else thr_grav = val[11:0];
  endtask

  // Stimulus
  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = 1'b0;
    in_ch.rate_x = '0; in_ch.rate_y = '0; in_ch.rate_z = '0;
    in_ch.elapsed_us = '0;
    in_ch.grav_x = '0; in_ch.grav_y = '0; in_ch.grav_z = '0;
    out_ch.ready = 1'b0;
    track_reset();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, wrap, overflow, weak and zero gravity
    pending_reqs.push_back(step_req(0, 0, 0, 0));
    pending_reqs.push_back(step_req(32767, 0, 0, 10000));
    pending_reqs.push_back(step_req(-32768, -32768, -32768, 65535));
    pending_reqs.push_back(step_req(32767, 32767, 32767, 65535));
    pending_reqs.push_back(step_req(0, 1608, 0, 1000));
    pending_reqs.push_back(step_req(-1, 1, -1, 1));
    pending_reqs.push_back(rezero_req(0, 0, 0));
    pending_reqs.push_back(rezero_req(0, 0, -981));
    pending_reqs.push_back(rezero_req(-32768, -32768, -32768));
    pending_reqs.push_back(rezero_req(32767, 32767, 32767));
    pending_reqs.push_back(rezero_req(100, 100, 100));
    pending_reqs.push_back(rezero_req(-32768, 0, 0));
    pending_reqs.push_back(step_req(3217, 0, 0, 10000));
    pending_reqs.push_back(step_req(0, 0, 32767, 65535));
    wait_drained();

    // Phases over register settings, extremes included
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_MIN_ROTATION, 16'd0);
          write_reg(REG_MIN_GRAVITY, 16'd0);
        end
        1: begin
          write_reg(REG_MIN_ROTATION, 16'd32768);
          write_reg(REG_MIN_GRAVITY, 16'd4000);
        end
        2: begin
          write_reg(REG_MIN_ROTATION, 16'($urandom_range(0, 32768)));
          write_reg(REG_MIN_GRAVITY, 16'($urandom_range(0, 4000)));
        end
        default: begin
          write_reg(REG_MIN_ROTATION, 16'd8192);
          write_reg(REG_MIN_GRAVITY, 16'd800);
        end
      endcase
      if (ph == 0) pending_reqs.push_back(rezero_req(0, 0, 0));
      for (int i = 0; i < NUM_RANDOM / 4; i++) pending_reqs.push_back(random_req());
      wait_drained();
    end

    $display("Covered %0d results, %0d tumbled, %0d weak-gravity fallbacks,",
             n_results, n_tumbled, n_low);
    $display("over four threshold settings with random gaps and stalls.");
    if (n_fail == 0 && expected_res.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
